/* rtl/core/s3cf_pkg.sv */
// ----------------------------------------------------------------------------
// s3cf_pkg
// Shared types and constants for the 3x3 cross sharpening filter: register
// indexes, reset values, size defaults and the job record that travels from
// the front end to the back end.
// ----------------------------------------------------------------------------
package s3cf_pkg;

	// Default size limits
	localparam int MAX_WIDTH_DEF    = 2048;
	localparam int MAX_HEIGHT_DEF   = 2048;
	localparam int MAX_CHANNELS_DEF = 4;

	// Register reset values and lower limits
	localparam int IMAGE_WIDTH_RESET   = 640;
	localparam int IMAGE_HEIGHT_RESET  = 480;
	localparam int CHANNEL_COUNT_RESET = 1;
	localparam int MIN_WIDTH           = 3;
	localparam int MIN_HEIGHT          = 3;
	localparam int MIN_CHANNELS        = 1;

	// Port widths fixed by the register and sample formats
	localparam int SAMPLE_W   = 8;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_ADDR_W = 2;

	// Center weight of the kernel
	localparam int SHARPEN_GAIN = 5;

	// Entries in the job queue between front and back end
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_IMAGE_HEIGHT  = 2'd1,
		REG_CHANNEL_COUNT = 2'd2
	} cfg_reg_t;

	// One classified input item with its neighborhood
	typedef struct packed {
		logic [SAMPLE_W-1:0] center;
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
		logic [SAMPLE_W-1:0] upper;
		logic [SAMPLE_W-1:0] lower;
		logic                interior;   // neighborhood fully inside the frame
		logic                has_up;     // result for the row above is due
		logic                has_bottom; // bottom border result is due
		logic                last;       // bottom result closes the frame
	} job_t;

endpackage

/* rtl/core/sharpen_3x3_cross_filter.sv */
// ----------------------------------------------------------------------------
// sharpen_3x3_cross_filter
// 3x3 cross sharpening filter over a channel-interleaved 8-bit raster stream.
// ----------------------------------------------------------------------------
// The filter takes one sample per clock in raster order, channels interleaved,
// and for a sample in row r returns the sharpened sample at the same position
// of row r-1 (5 x center minus left, right, upper and lower neighbors of the
// same channel, clamped to 0..255, zero on border rows and pixels). Row 0 gives
// no result; on the last row each sample also yields a zero bottom-border
// result, and the last of these carries frame_last. Input is sustained at one
// sample per clock unless out_stall holds it; on the last row the output side
// emits two results per sample, and the four-entry job queue plus input stall
// absorb that. Two line stores of MAX_WIDTH * MAX_CHANNELS bytes each (one
// write and two read ports) hold the previous rows; their content after reset
// never reaches a result, so no clearing pass runs. Register writes are
// clamped into range and restart the frame.
// ----------------------------------------------------------------------------
module sharpen_3x3_cross_filter import s3cf_pkg::*; #(
	parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT   = MAX_HEIGHT_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [SAMPLE_W-1:0]   sample,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic [SAMPLE_W-1:0]   pixel_out,
	output logic                  frame_last,
	output logic                  out_valid,
	input  logic                  out_stall
);

	localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int LEN_W      = $clog2(LINE_DEPTH + 1);
	localparam int W_W        = $clog2(MAX_WIDTH + 1);
	localparam int H_W        = $clog2(MAX_HEIGHT + 1);
	localparam int C_W        = $clog2(MAX_CHANNELS + 1);
	localparam int RST_WIDTH  = (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH :
		IMAGE_WIDTH_RESET;
	localparam int RST_HEIGHT = (IMAGE_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT :
		IMAGE_HEIGHT_RESET;

	logic [W_W-1:0]   width_q;
	logic [H_W-1:0]   height_q;
	logic [C_W-1:0]   chan_q;
	logic [31:0]      data_ext;
	logic [31:0]      width_clamp;
	logic [31:0]      height_clamp;
	logic [31:0]      chan_clamp;
	logic             restart;
	logic [LEN_W-1:0] len;
	logic             q_full;
	logic             push;
	job_t             push_job;
	logic             pop;
	logic             head_valid;
	job_t             head;

	// Clamp written values into their legal ranges
	always_comb begin
		data_ext     = 32'(cfg_wdata);
		width_clamp  = (data_ext < 32'(MIN_WIDTH)) ? 32'(MIN_WIDTH) :
			(data_ext > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : data_ext;
		height_clamp = (data_ext < 32'(MIN_HEIGHT)) ? 32'(MIN_HEIGHT) :
			(data_ext > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : data_ext;
		chan_clamp   = (32'(cfg_wdata[2:0]) < 32'(MIN_CHANNELS)) ? 32'(MIN_CHANNELS) :
			(32'(cfg_wdata[2:0]) > 32'(MAX_CHANNELS)) ? 32'(MAX_CHANNELS) :
			32'(cfg_wdata[2:0]);
	end

	// Any write to a known register restarts the frame
	always_comb begin
		restart = 1'b0;
		if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_CHANNEL_COUNT: restart = 1'b1;
				default: restart = 1'b0;
			endcase
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= W_W'(RST_WIDTH);
			height_q <= H_W'(RST_HEIGHT);
			chan_q   <= C_W'(CHANNEL_COUNT_RESET);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_IMAGE_WIDTH:   width_q  <= W_W'(width_clamp);
				REG_IMAGE_HEIGHT:  height_q <= H_W'(height_clamp);
				REG_CHANNEL_COUNT: chan_q   <= C_W'(chan_clamp);
				default: ;
			endcase
		end
	end

	// Samples per row
	assign len = LEN_W'(width_q) * LEN_W'(chan_q);

	s3cf_front #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.len      (len),
		.chan     (chan_q),
		.height   (height_q),
		.sample   (sample),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.q_full   (q_full),
		.push     (push),
		.job      (push_job)
	);

	s3cf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	s3cf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.pixel_out  (pixel_out),
		.frame_last (frame_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

endmodule

/* rtl/core/s3cf_front.sv */
// ----------------------------------------------------------------------------
// s3cf_front
// Input side: position counters, the two line stores, a short tap line over
// the middle-row reads and classification of each sample into a job.
// ----------------------------------------------------------------------------
module s3cf_front import s3cf_pkg::*; #(
	parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT   = MAX_HEIGHT_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	localparam int LINE_DEPTH  = MAX_WIDTH * MAX_CHANNELS,
	localparam int LEN_W       = $clog2(LINE_DEPTH + 1),
	localparam int H_W         = $clog2(MAX_HEIGHT + 1),
	localparam int C_W         = $clog2(MAX_CHANNELS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                restart,
	input  logic [LEN_W-1:0]    len,
	input  logic [C_W-1:0]      chan,
	input  logic [H_W-1:0]      height,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                q_full,
	output logic                push,
	output job_t                job
);

	localparam int COL_W = $clog2(LINE_DEPTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic                accept;
	logic                consume;
	logic                last_col;
	logic                last_row;
	logic                has_up;
	logic                interior;
	logic [LEN_W-1:0]    col_ext;
	logic [LEN_W-1:0]    chan_ext;
	logic [COL_W-1:0]    addr_plus;
	logic [COL_W-1:0]    addr_minus;
	logic [COL_W-1:0]    b0_addr1;
	logic [COL_W-1:0]    b1_addr1;
	logic                par;

	logic [SAMPLE_W-1:0] line_upper  [LINE_DEPTH];
	logic [SAMPLE_W-1:0] line_middle [LINE_DEPTH];

	logic [SAMPLE_W-1:0] b0_rd1_s1;
	logic [SAMPLE_W-1:0] b0_rd2_s1;
	logic [SAMPLE_W-1:0] b1_rd1_s1;
	logic [SAMPLE_W-1:0] b1_rd2_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                valid_s1;
	logic                par_s1;
	logic                has_up_s1;
	logic                interior_s1;
	logic                last_row_s1;
	logic                last_col_s1;

	logic [SAMPLE_W-1:0] dly_q [MAX_CHANNELS];
	logic [SAMPLE_W-1:0] mid_a;
	logic [SAMPLE_W-1:0] mid_b;
	logic [SAMPLE_W-1:0] cur;
	logic [SAMPLE_W-1:0] mid_center;
	logic                needed;

	// Stage 1 frees when its job moves into the queue or needs no result
	assign needed   = has_up_s1 || last_row_s1;
	assign consume  = valid_s1 && (!needed || !q_full);
	assign in_stall = valid_s1 && !consume;
	assign accept   = in_valid && !in_stall;

	// Classify the current position
	assign col_ext  = LEN_W'(col_q);
	assign chan_ext = LEN_W'(chan);
	assign last_col = (col_ext == len - LEN_W'(1));
	assign last_row = (H_W'(row_q) == height - H_W'(1));
	assign has_up   = (row_q != '0);
	assign interior = (row_q >= ROW_W'(2)) && (col_ext >= chan_ext) &&
		(col_ext < len - chan_ext);

	// Advance the position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Even rows live in line_upper, odd rows in line_middle. The store of the
	// current row is read at the column before it is overwritten; the store of
	// the row above is read one pixel ahead and one pixel behind.
	assign par        = row_q[0];
	assign addr_plus  = col_q + COL_W'(chan);
	assign addr_minus = col_q - COL_W'(chan);
	assign b0_addr1   = par ? addr_plus : col_q;
	assign b1_addr1   = par ? col_q : addr_plus;

	always_ff @(posedge clk) begin
		if (accept) begin
			b0_rd1_s1 <= line_upper[b0_addr1];
			b0_rd2_s1 <= line_upper[addr_minus];
			if (!par) begin
				line_upper[col_q] <= sample;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			b1_rd1_s1 <= line_middle[b1_addr1];
			b1_rd2_s1 <= line_middle[addr_minus];
			if (par) begin
				line_middle[col_q] <= sample;
			end
		end
	end

	// Stage 1 occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1   <= sample;
			par_s1      <= par;
			has_up_s1   <= has_up;
			interior_s1 <= interior;
			last_row_s1 <= last_row;
			last_col_s1 <= last_col;
		end
	end

	// Route bank reads to their roles
	assign cur   = par_s1 ? b1_rd1_s1 : b0_rd1_s1;
	assign mid_a = par_s1 ? b0_rd1_s1 : b1_rd1_s1;
	assign mid_b = par_s1 ? b0_rd2_s1 : b1_rd2_s1;

	// Hold the last few look-ahead reads; the one taken a pixel ago is the center
	always_ff @(posedge clk) begin
		if (consume) begin
			dly_q[0] <= mid_a;
			for (int j = 1; j < MAX_CHANNELS; j++) begin
				dly_q[j] <= dly_q[j-1];
			end
		end
	end

	always_comb begin
		mid_center = dly_q[0];
		for (int j = 0; j < MAX_CHANNELS; j++) begin
			if (C_W'(j + 1) == chan) begin
				mid_center = dly_q[j];
			end
		end
	end

	// Build the job for the back end
	assign push = consume && needed;

	always_comb begin
		job            = '0;
		job.center     = mid_center;
		job.left       = mid_b;
		job.right      = mid_a;
		job.upper      = cur;
		job.lower      = sample_s1;
		job.interior   = interior_s1;
		job.has_up     = has_up_s1;
		job.has_bottom = last_row_s1;
		job.last       = last_row_s1 && last_col_s1;
	end

endmodule

/* rtl/core/s3cf_queue.sv */
// ----------------------------------------------------------------------------
// s3cf_queue
// Small register FIFO of jobs that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module s3cf_queue import s3cf_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Store a pushed job
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* rtl/core/s3cf_back.sv */
// ----------------------------------------------------------------------------
// s3cf_back
// Output side: evaluates the cross kernel for the job at the queue head and
// emits one or two result transactions through an output register.
// ----------------------------------------------------------------------------
module s3cf_back import s3cf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  job_t                head,
	output logic                pop,
	output logic [SAMPLE_W-1:0] pixel_out,
	output logic                frame_last,
	output logic                out_valid,
	input  logic                out_stall
);

	typedef enum logic {
		PH_UPPER,
		PH_BOTTOM
	} phase_t;

	phase_t              phase_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] pixel_out_q;
	logic                frame_last_q;
	logic                load;
	logic                emit_upper;
	logic [10:0]         gain_sum;
	logic [9:0]          nb_sum;
	logic [10:0]         diff;
	logic [SAMPLE_W-1:0] sharp;
	logic [SAMPLE_W-1:0] value;

	// Kernel: five times the center minus the four neighbors, clamped
	always_comb begin
		gain_sum = 11'(head.center) * 11'(SHARPEN_GAIN);
		nb_sum   = 10'(head.left) + 10'(head.right) + 10'(head.upper) + 10'(head.lower);
		diff     = gain_sum - 11'(nb_sum);
		if (gain_sum <= 11'(nb_sum)) begin
			sharp = '0;
		end else if (diff > 11'd255) begin
			sharp = '1;
		end else begin
			sharp = diff[SAMPLE_W-1:0];
		end
		value = head.interior ? sharp : '0;
	end

	assign load       = !out_valid_q || !out_stall;
	assign emit_upper = head_valid && head.has_up && (phase_q == PH_UPPER);
	assign pop        = load && head_valid && !(emit_upper && head.has_bottom);

	// Emit the upper-row result first, then the bottom border result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_UPPER;
			out_valid_q  <= 1'b0;
			pixel_out_q  <= '0;
			frame_last_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (emit_upper) begin
				pixel_out_q  <= value;
				frame_last_q <= 1'b0;
				if (head.has_bottom) begin
					phase_q <= PH_BOTTOM;
				end
			end else begin
				pixel_out_q  <= '0;
				frame_last_q <= head.last;
				phase_q      <= PH_UPPER;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_out_q;
	assign frame_last = frame_last_q;

endmodule

/* rtl/core/s3cf_checker.sv */
// ----------------------------------------------------------------------------
// s3cf_checker
// Port-level checks for the sharpening filter, bound to the top level.
// ----------------------------------------------------------------------------
module s3cf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] pixel_out,
	input logic       frame_last,
	input logic       out_valid,
	input logic       out_stall
);

	// A stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(frame_last))
		else $error("result changed while stalled");

	// The frame closes on a bottom border result, which is always zero
	a_last_is_border: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> pixel_out == 8'd0)
		else $error("frame end result is not a border zero");

	// No result right after reset
	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result shown right after reset");

	// No input stall right after reset, the front end is empty
	a_ready_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !in_stall)
		else $error("input stalled right after reset");

	// An open input with no transaction stays open on the next cycle
	a_stall_needs_input: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid && !in_stall |=> !in_stall)
		else $error("input stalled without a transaction");

endmodule

bind sharpen_3x3_cross_filter s3cf_checker u_s3cf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.pixel_out  (pixel_out),
	.frame_last (frame_last),
	.out_valid  (out_valid),
	.out_stall  (out_stall)
);
